### src/fdah_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the gray conversion for the frame difference heatmap.
// No dependencies; every other file of the block imports this package.
package fdah_pkg;

	// Default sizes of the block.
	localparam int MaxPixelsDef = 524288;
	localparam int CountBitsDef = 16;

	// Fixed field widths of the channels.
	localparam int ColorW    = 8;
	localparam int ThreshW   = 8;
	localparam int FrameW    = 16;
	localparam int HeatW     = 16;
	localparam int ChangesW  = 20;
	localparam int CfgIdxW   = 4;
	localparam int CfgDataW  = 16;

	// BT.601 luma weights in 14-bit fixed point, with rounding.
	localparam int GrayFracBits = 14;
	localparam int GraySumW     = 22;
	localparam logic [GrayFracBits-1:0] WeightBlue  = 14'd1868;
	localparam logic [GrayFracBits-1:0] WeightGreen = 14'd9617;
	localparam logic [GrayFracBits-1:0] WeightRed   = 14'd4899;
	localparam logic [GraySumW-1:0]     GrayRound   = 22'd8192;

	// Register reset values.
	localparam logic [ThreshW-1:0] ThreshRst = 8'd127;
	localparam logic [FrameW-1:0]  StartRst  = 16'd0;
	localparam logic [FrameW-1:0]  EndRst    = 16'hFFFF;
	localparam logic               LimitRst  = 1'b0;

	// Saturation limits.
	localparam logic [FrameW-1:0]   FrameMax   = {FrameW{1'b1}};
	localparam logic [ChangesW-1:0] ChangesMax = {ChangesW{1'b1}};

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_GRAY_THRESHOLD = 4'd0,
		REG_START_FRAME    = 4'd1,
		REG_END_FRAME      = 4'd2,
		REG_END_LIMIT_ON   = 4'd3
	} cfg_reg_t;

	// Weighted color sum before the fraction bits are dropped.
	function automatic logic [GraySumW-1:0] gray_sum(
		input logic [ColorW-1:0] blue,
		input logic [ColorW-1:0] green,
		input logic [ColorW-1:0] red
	);
		gray_sum = GraySumW'(WeightBlue) * GraySumW'(blue)
			+ GraySumW'(WeightGreen) * GraySumW'(green)
			+ GraySumW'(WeightRed) * GraySumW'(red)
			+ GrayRound;
	endfunction

endpackage

### src/fdah_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the frame difference heatmap: pixel input, result output, config writes.
// Depends on fdah_pkg for the field widths.

// Pixel stream, one pixel per word.
interface fdah_pix_if;
	import fdah_pkg::*;
	logic              valid;
	logic              ready;
	logic [ColorW-1:0] blue;
	logic [ColorW-1:0] green;
	logic [ColorW-1:0] red;
	logic              frame_end;

	modport source(output valid, blue, green, red, frame_end, input ready);
	modport sink(input valid, blue, green, red, frame_end, output ready);
endinterface

// Result stream, one word per pixel.
interface fdah_res_if;
	import fdah_pkg::*;
	logic                valid;
	logic                ready;
	logic                changed;
	logic [HeatW-1:0]    heat_count;
	logic [ChangesW-1:0] frame_changes;
	logic                counting;
	logic                frame_done;

	modport source(output valid, changed, heat_count, frame_changes, counting, frame_done,
		input ready);
	modport sink(input valid, changed, heat_count, frame_changes, counting, frame_done,
		output ready);
endinterface

// Register write channel.
interface fdah_cfg_if;
	import fdah_pkg::*;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/frame_difference_activity_heatmap.sv
`timescale 1ns / 1ps
// Top level of the frame difference activity heatmap: pixel pipeline and heat memory.
// Depends on fdah_pkg and the channel interfaces in fdah_if.sv.

// The block takes one BGR pixel per clock in raster order while the result channel is not
// stalled, and returns one result word per pixel. The result word passes through the stage
// one, stage two and output registers after the pixel word is accepted. The sustained rate holds
// because the per-pixel memory has one read port used at accept time and one write port used
// when the result is registered; the two words still in flight ahead of a pixel are forwarded
// to it, so short frames and repeated positions need no stall. The memory holds the
// previous binary bit and the saturating activity count of every pixel position. Counts read
// as zero until a position is first visited: a fill mark tracks how far the raster has reached
// since reset, so there is no clearing pass and the block is ready right after reset. Register
// writes are taken at any time but must only be issued while no pixel is in flight; they apply
// from the next pixel.
module frame_difference_activity_heatmap #(
	parameter int MAX_PIXELS = fdah_pkg::MaxPixelsDef,
	parameter int COUNT_BITS = fdah_pkg::CountBitsDef
) (
	input logic        clk,
	input logic        arst_n,
	fdah_cfg_if.sink   cfg,
	fdah_pix_if.sink   pix,
	fdah_res_if.source res
);
	import fdah_pkg::*;

	localparam int AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int FillW = $clog2(MAX_PIXELS + 1);
	localparam logic [AddrW-1:0]      LastPos  = AddrW'(MAX_PIXELS - 1);
	localparam logic [FillW-1:0]      FillFull = FillW'(MAX_PIXELS);
	localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

	// One memory entry: previous binary bit and activity count.
	typedef struct packed {
		logic                  prev;
		logic [COUNT_BITS-1:0] cnt;
	} entry_t;

	// Per-pixel control that travels with the word.
	typedef struct packed {
		logic frame_end;
		logic counting;
		logic reference;
		logic filled;
	} ctl_t;

	// Configuration registers.
	logic [ThreshW-1:0] thresh_q;
	logic [FrameW-1:0]  start_q;
	logic [FrameW-1:0]  end_q;
	logic               limit_q;

	// Raster position, frame number and fill mark.
	logic [AddrW-1:0]  pos_q;
	logic [FrameW-1:0] frame_q;
	logic [FillW-1:0]  fill_q;

	// Heat memory.
	entry_t heat_mem [MAX_PIXELS];

	// Pipeline registers.
	logic              v_s1;
	logic [ColorW-1:0] blue_s1;
	logic [ColorW-1:0] green_s1;
	logic [ColorW-1:0] red_s1;
	logic [AddrW-1:0]  addr_s1;
	ctl_t              ctl_s1;
	entry_t            rd_s1;

	logic              v_s2;
	logic              bit_s2;
	logic [AddrW-1:0]  addr_s2;
	ctl_t              ctl_s2;
	entry_t            rd_s2;

	// The two most recent memory writes, newest first.
	logic              h1_v_q;
	logic [AddrW-1:0]  h1_addr_q;
	entry_t            h1_q;
	logic              h2_v_q;
	logic [AddrW-1:0]  h2_addr_q;
	entry_t            h2_q;

	// Frame change total and output register.
	logic [ChangesW-1:0] chg_cnt_q;
	logic                out_v_q;
	logic                changed_q;
	logic [HeatW-1:0]    heat_q;
	logic [ChangesW-1:0] frame_changes_q;
	logic                counting_q;
	logic                frame_done_q;

	// Handshake and stage movement.
	logic in_acc;
	logic out_free;
	logic s2_adv;
	logic s2_free;
	logic s1_adv;

	// Combinational results.
	logic                is_ref;
	logic                is_cnt;
	logic                filled;
	logic [GraySumW-1:0] sum_s1;
	logic [ThreshW-1:0]  gray_s1;
	logic                bit_s1;
	entry_t              cur;
	logic                chg;
	entry_t              wr_entry;
	logic [ChangesW-1:0] chg_next;

	// Stages move forward whenever the next one is empty or emptying.
	assign out_free  = !out_v_q || res.ready;
	assign s2_adv    = v_s2 && out_free;
	assign s2_free   = !v_s2 || out_free;
	assign s1_adv    = v_s1 && s2_free;
	assign pix.ready = !v_s1 || s2_free;
	assign in_acc    = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshRst;
			start_q  <= StartRst;
			end_q    <= EndRst;
			limit_q  <= LimitRst;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GRAY_THRESHOLD: thresh_q <= cfg.data[ThreshW-1:0];
				REG_START_FRAME:    start_q  <= cfg.data[FrameW-1:0];
				REG_END_FRAME:      end_q    <= cfg.data[FrameW-1:0];
				REG_END_LIMIT_ON:   limit_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Frame class and fill state of the pixel at the input.
	assign is_ref = (frame_q == start_q);
	assign is_cnt = (frame_q > start_q) && (!limit_q || (frame_q <= end_q));
	assign filled = (FillW'(pos_q) < fill_q);

	// Raster position, frame counter and fill mark advance per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			frame_q <= '0;
			fill_q  <= '0;
		end else if (in_acc) begin
			if (pix.frame_end) begin
				pos_q <= '0;
				if (frame_q != FrameMax) begin
					frame_q <= frame_q + FrameW'(1);
				end
			end else if (pos_q == LastPos) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + AddrW'(1);
			end
			if ((fill_q != FillFull) && (FillW'(pos_q) == fill_q)) begin
				fill_q <= fill_q + FillW'(1);
			end
		end
	end

	// Memory: read at accept, write when the result is registered.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= heat_mem[pos_q];
		end
		if (s2_adv) begin
			heat_mem[addr_s2] <= wr_entry;
		end
	end

	// Stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			blue_s1          <= pix.blue;
			green_s1         <= pix.green;
			red_s1           <= pix.red;
			addr_s1          <= pos_q;
			ctl_s1.frame_end <= pix.frame_end;
			ctl_s1.counting  <= is_cnt;
			ctl_s1.reference <= is_ref;
			ctl_s1.filled    <= filled;
		end
	end

	// Gray level and binary bit.
	assign sum_s1  = gray_sum(blue_s1, green_s1, red_s1);
	assign gray_s1 = sum_s1[GraySumW-1:GrayFracBits];
	assign bit_s1  = (gray_s1 > thresh_q);

	// Stage two valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			bit_s2  <= bit_s1;
			addr_s2 <= addr_s1;
			ctl_s2  <= ctl_s1;
			rd_s2   <= rd_s1;
		end
	end

	// Current entry: newest in-flight write wins, then memory; unvisited counts read zero.
	always_comb begin
		if (h1_v_q && (h1_addr_q == addr_s2)) begin
			cur = h1_q;
		end else if (h2_v_q && (h2_addr_q == addr_s2)) begin
			cur = h2_q;
		end else begin
			cur.prev = rd_s2.prev;
			cur.cnt  = ctl_s2.filled ? rd_s2.cnt : '0;
		end
	end

	// Compare, count and store.
	always_comb begin
		chg          = ctl_s2.counting && (cur.prev != bit_s2);
		wr_entry.prev = (ctl_s2.counting || ctl_s2.reference) ? bit_s2 : cur.prev;
		wr_entry.cnt  = (chg && (cur.cnt != CountMax)) ? cur.cnt + COUNT_BITS'(1) : cur.cnt;
		chg_next      = (chg && (chg_cnt_q != ChangesMax)) ?
			chg_cnt_q + ChangesW'(1) : chg_cnt_q;
	end

	// Write history, frame change total and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_v_q    <= 1'b0;
			h2_v_q    <= 1'b0;
			chg_cnt_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (s2_adv) begin
				h1_v_q    <= 1'b1;
				h2_v_q    <= h1_v_q;
				chg_cnt_q <= ctl_s2.frame_end ? '0 : chg_next;
				out_v_q   <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// History and result payload.
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			h1_addr_q       <= addr_s2;
			h1_q            <= wr_entry;
			h2_addr_q       <= h1_addr_q;
			h2_q            <= h1_q;
			changed_q       <= chg;
			heat_q          <= HeatW'(wr_entry.cnt);
			frame_changes_q <= chg_next;
			counting_q      <= ctl_s2.counting;
			frame_done_q    <= ctl_s2.frame_end;
		end
	end

	assign res.valid         = out_v_q;
	assign res.changed       = changed_q;
	assign res.heat_count    = heat_q;
	assign res.frame_changes = frame_changes_q;
	assign res.counting      = counting_q;
	assign res.frame_done    = frame_done_q;

endmodule

### src/fdah_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the frame difference heatmap, bound to the top level.
// Depends on fdah_pkg and on the port names of frame_difference_activity_heatmap.
module fdah_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_changed,
	input logic [fdah_pkg::HeatW-1:0]    out_heat_count,
	input logic [fdah_pkg::ChangesW-1:0] out_frame_changes,
	input logic                          out_counting,
	input logic                          out_frame_done
);
	import fdah_pkg::*;

	logic [2:0]          pending_q;
	logic                prev_done_q;
	logic [ChangesW-1:0] prev_fc_q;
	logic [ChangesW-1:0] base;
	logic [ChangesW-1:0] expect_fc;
	logic                in_acc;
	logic                out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Words accepted but not yet delivered, and the last delivered frame total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			prev_done_q <= 1'b1;
			prev_fc_q   <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc) begin
				prev_done_q <= out_frame_done;
				prev_fc_q   <= out_frame_changes;
			end
		end
	end

	// Running total expected from the previous word of the same frame.
	assign base      = prev_done_q ? '0 : prev_fc_q;
	assign expect_fc = (out_changed && (base != ChangesMax)) ? base + ChangesW'(1) : base;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({out_changed, out_heat_count, out_frame_changes, out_counting, out_frame_done}))
		else $error("result word changed while stalled");

	// A change is only reported inside the accumulation window.
	a_chg_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_changed |-> out_counting)
		else $error("change reported outside the accumulation window");

	// No result appears without an accepted pixel behind it.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 3'd0))
		else $error("result word without an accepted pixel");

	// The frame total grows by exactly the changed flag and restarts after a frame end.
	a_frame_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (out_frame_changes == expect_fc))
		else $error("frame change total out of step");

endmodule

bind frame_difference_activity_heatmap fdah_checker u_fdah_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (pix.valid),
	.in_ready         (pix.ready),
	.out_valid        (res.valid),
	.out_ready        (res.ready),
	.out_changed      (res.changed),
	.out_heat_count   (res.heat_count),
	.out_frame_changes(res.frame_changes),
	.out_counting     (res.counting),
	.out_frame_done   (res.frame_done)
);

### test/frame_difference_activity_heatmap_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame difference activity heatmap: pixel words go in from a
// queue, result words are checked against an in-bench model of the gray/threshold/XOR counter.
// Depends on fdah_pkg, the channel interfaces in fdah_if.sv and the block's top level.
module frame_difference_activity_heatmap_test;
	import fdah_pkg::*;

	// Sizes and limits of the run.
	localparam int unsigned CycleLimit   = 100_000;
	localparam int unsigned ReportLimit  = 40;
	localparam int unsigned SceneSlots   = 64;
	localparam int unsigned LongFrameLen = 300;
	localparam int unsigned DrainCycles  = 20;

	// BT.601 weights in 14-bit fixed point with half-unit rounding.
	localparam int unsigned LumaBlue  = 1868;
	localparam int unsigned LumaGreen = 9617;
	localparam int unsigned LumaRed   = 4899;
	localparam int unsigned LumaRound = 8192;
	localparam int unsigned LumaShift = 14;

	localparam bit [CountBitsDef-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		FRAME_SKIP,
		FRAME_REFERENCE,
		FRAME_COUNT
	} frame_kind_t;

	typedef struct packed {
		logic [ColorW-1:0] blue;
		logic [ColorW-1:0] green;
		logic [ColorW-1:0] red;
		logic              frame_end;
	} pixel_t;

	typedef struct packed {
		logic                changed;
		logic [HeatW-1:0]    heat_count;
		logic [ChangesW-1:0] frame_changes;
		logic                counting;
		logic                frame_done;
	} heat_word_t;

	logic clk;
	logic arst_n;

	fdah_cfg_if cfg_ch();
	fdah_pix_if pix_ch();
	fdah_res_if res_ch();

	frame_difference_activity_heatmap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	// Register copies, written only while no pixel is in flight.
	logic [ThreshW-1:0] thr_reg   = ThreshRst;
	logic [FrameW-1:0]  start_reg = StartRst;
	logic [FrameW-1:0]  end_reg   = EndRst;
	logic               limit_reg = LimitRst;

	// Model state of the block.
	bit                    prev_bit_mem [MaxPixelsDef];
	bit [CountBitsDef-1:0] heat_mem     [MaxPixelsDef];
	int unsigned           pix_pos     = 0;
	logic [FrameW-1:0]     frame_idx   = '0;
	logic [ChangesW-1:0]   frame_total = '0;

	// Stimulus side: pending pixels, expected result words, and the generator's own raster.
	pixel_t                pixel_queue [$];
	heat_word_t            heat_due    [$];
	logic [FrameW-1:0]     gen_frame   = '0;
	int unsigned           gen_pos     = 0;
	int unsigned           gen_written = 0;
	bit [3*ColorW-1:0]     scene [SceneSlots];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches     = 0;
	int unsigned cycles         = 0;
	pixel_t      next_px;
	pixel_t      bus_px;
	heat_word_t  want;

	// Class of a frame under the current window registers.
	function automatic frame_kind_t frame_kind(logic [FrameW-1:0] f);
		if (f == start_reg)
			return FRAME_REFERENCE;
		if (f > start_reg && (!limit_reg || f <= end_reg))
			return FRAME_COUNT;
		return FRAME_SKIP;
	endfunction

	// Advances the model by one accepted pixel and returns the result word it must produce.
	function automatic heat_word_t accumulate_pixel(pixel_t px);
		int unsigned luma;
		bit          level;
		frame_kind_t kind;
		heat_word_t  w;
		luma = (LumaBlue * px.blue + LumaGreen * px.green + LumaRed * px.red + LumaRound)
			>> LumaShift;
		level = luma > thr_reg;
		kind = frame_kind(frame_idx);
		w = '0;
		if (kind == FRAME_COUNT) begin
			if (prev_bit_mem[pix_pos] != level) begin
				w.changed = 1'b1;
				if (heat_mem[pix_pos] != CountMax)
					heat_mem[pix_pos]++;
				if (frame_total != ChangesMax)
					frame_total++;
			end
			prev_bit_mem[pix_pos] = level;
		end else if (kind == FRAME_REFERENCE) begin
			prev_bit_mem[pix_pos] = level;
		end
		w.heat_count    = HeatW'(heat_mem[pix_pos]);
		w.frame_changes = frame_total;
		w.counting      = kind == FRAME_COUNT;
		w.frame_done    = px.frame_end;
		if (px.frame_end) begin
			pix_pos = 0;
			frame_total = '0;
			if (frame_idx != FrameMax)
				frame_idx++;
		end else begin
			pix_pos = (pix_pos == MaxPixelsDef - 1) ? 0 : pix_pos + 1;
		end
		return w;
	endfunction

	// Queues one pixel. A counting frame is cut short before it would reach a position that
	// no earlier frame has stored, since that bit is undefined in the block.
	function automatic void queue_pixel(logic [ColorW-1:0] b, logic [ColorW-1:0] g,
			logic [ColorW-1:0] r, bit last);
		frame_kind_t kind;
		pixel_t      px;
		kind = frame_kind(gen_frame);
		if (kind == FRAME_COUNT && gen_written < MaxPixelsDef && gen_pos + 1 >= gen_written)
			last = 1'b1;
		px = {b, g, r, last};
		pixel_queue.insert(pixel_queue.size(), px);
		if (kind != FRAME_SKIP && gen_pos + 1 > gen_written)
			gen_written = gen_pos + 1;
		if (last) begin
			gen_pos = 0;
			if (gen_frame != FrameMax)
				gen_frame++;
		end else begin
			gen_pos = (gen_pos == MaxPixelsDef - 1) ? 0 : gen_pos + 1;
		end
	endfunction

	// Whole frames of random length. Pixels often repeat or barely alter the color last used
	// at their position, so bits both hold and flip between frames.
	function automatic void queue_random_frames(int unsigned n_items, int unsigned max_len);
		int unsigned       queued;
		int unsigned       len;
		int unsigned       slot;
		bit [3*ColorW-1:0] c;
		queued = 0;
		while (queued < n_items) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(LongFrameLen, 1)
				: $urandom_range(max_len, 1);
			for (int i = 0; i < len; i++) begin
				slot = gen_pos % SceneSlots;
				case ($urandom_range(3))
					0: c = scene[slot];
					1: c = scene[slot] ^ ((3*ColorW)'(1) << $urandom_range(3*ColorW - 1));
					default: c = (3*ColorW)'($urandom);
				endcase
				scene[slot] = c;
				queue_pixel(c[3*ColorW-1:2*ColorW], c[2*ColorW-1:ColorW], c[ColorW-1:0],
					i == len - 1);
				queued++;
				if (gen_pos == 0)
					break;
			end
		end
	endfunction

	function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= ReportLimit)
				$error("%s: expected %0d, actual %0d", field, exp_v, act_v);
		end
	endfunction

	// Waits until every queued pixel has been taken and every result word has come back.
	// Sampled at the falling edge, once the driver's updates of the rising edge have settled.
	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pix_ch.valid || heat_due.size() != 0)
			@(negedge clk);
	endtask

	// One register write word; the register copy follows the block's masking.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_GRAY_THRESHOLD: thr_reg   = value[ThreshW-1:0];
			REG_START_FRAME:    start_reg = value;
			REG_END_FRAME:      end_reg   = value;
			REG_END_LIMIT_ON:   limit_reg = value[0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int unsigned n_items, input int unsigned max_len);
		queue_random_frames(n_items, max_len);
		wait_drained();
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pixel driver: takes the next pending pixel whenever the channel slot is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid     <= 1'b0;
			pix_ch.blue      <= '0;
			pix_ch.green     <= '0;
			pix_ch.red       <= '0;
			pix_ch.frame_end <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				bus_px = {pix_ch.blue, pix_ch.green, pix_ch.red, pix_ch.frame_end};
				heat_due.insert(heat_due.size(), accumulate_pixel(bus_px));
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_px = pixel_queue.pop_front();
					pix_ch.valid     <= 1'b1;
					pix_ch.blue      <= next_px.blue;
					pix_ch.green     <= next_px.green;
					pix_ch.red       <= next_px.red;
					pix_ch.frame_end <= next_px.frame_end;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every accepted word is matched against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (heat_due.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$error("result word with no pixel pending: heat_count %0d",
							res_ch.heat_count);
				end else begin
					want = heat_due.pop_front();
					check_field("changed", want.changed, res_ch.changed);
					check_field("heat_count", want.heat_count, res_ch.heat_count);
					check_field("frame_changes", want.frame_changes, res_ch.frame_changes);
					check_field("counting", want.counting, res_ch.counting);
					check_field("frame_done", want.frame_done, res_ch.frame_done);
				end
			end
			res_ch.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GRAY_THRESHOLD;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reference frame: black, white, and gray exactly at and just above the threshold.
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd127, 8'd127, 8'd127, 1'b0);
		queue_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		// Every bit inverted, then the same frame again with no change.
		repeat (2) begin
			queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
			queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
			queue_pixel(8'd128, 8'd128, 8'd128, 1'b0);
			queue_pixel(8'd127, 8'd127, 8'd127, 1'b1);
		end
		// Single full channels show each weight on its own.
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		// A one-pixel frame.
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		wait_drained();

		// Lowest threshold: only pixels whose gray level rounds to zero stay zero.
		write_reg(REG_GRAY_THRESHOLD, {8'($urandom), 8'd0});
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd1, 8'd1, 8'd1, 1'b1);
		run_phase(150, 40);

		// Highest threshold, reference three frames ahead; the sender idles most cycles.
		write_reg(REG_GRAY_THRESHOLD, {8'($urandom), 8'd255});
		write_reg(REG_START_FRAME, gen_frame + FrameW'(3));
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_idle_pct = 80;
		run_phase(150, 40);

		// Short window with the end limit on; the receiver stalls most cycles.
		send_idle_pct = 0;
		recv_stall_pct = 80;
		write_reg(REG_GRAY_THRESHOLD, 16'($urandom));
		write_reg(REG_START_FRAME, gen_frame);
		write_reg(REG_END_FRAME, gen_frame + FrameW'(3));
		write_reg(REG_END_LIMIT_ON, {15'($urandom), 1'b1});
		run_phase(150, 40);

		// Reference at the last frame index and window end at zero: every frame is skipped.
		// A write to an index past the register list must change nothing.
		send_idle_pct = 12;
		recv_stall_pct = 12;
		write_reg(REG_START_FRAME, FrameMax);
		write_reg(REG_END_FRAME, '0);
		write_reg(CfgIdxW'($urandom_range(15, 4)), 16'($urandom));
		run_phase(100, 40);

		// Window end before the reference: the reference frame stores, nothing counts.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_START_FRAME, gen_frame + FrameW'(1));
		write_reg(REG_END_FRAME, gen_frame);
		run_phase(100, 40);

		// Reference in the past, no end limit: counting starts at once. The sender
		// pauses halfway until every result word is back.
		send_idle_pct = 12;
		recv_stall_pct = 12;
		write_reg(REG_GRAY_THRESHOLD, 16'($urandom));
		write_reg(REG_START_FRAME, gen_frame - FrameW'(1));
		write_reg(REG_END_FRAME, EndRst);
		write_reg(REG_END_LIMIT_ON, {15'($urandom), 1'b0});
		run_phase(120, 40);
		run_phase(120, 40);

		// Limit on with the largest window end.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_GRAY_THRESHOLD, 16'($urandom));
		write_reg(REG_START_FRAME, gen_frame);
		write_reg(REG_END_LIMIT_ON, {15'($urandom), 1'b1});
		run_phase(110, 40);

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
